// ===== hdl/lrp_pkg.sv =====
// Shared constants, codes and control structs for the LR parse engine.
package lrp_pkg;

    // Default sizes
    localparam int NUM_STATES_DEF      = 64;
    localparam int NUM_SYMBOLS_DEF     = 16;
    localparam int NUM_PRODUCTIONS_DEF = 64;
    localparam int STACK_DEPTH_DEF     = 64;
    localparam int MAX_REDUCES_DEF     = 63;

    // Reach of the fixed-width row and column fields
    localparam int ROW_SPAN = 64;
    localparam int COL_SPAN = 16;

    // Commands
    localparam logic [1:0] CMD_TOKEN     = 2'd0;
    localparam logic [1:0] CMD_LOAD_ACT  = 2'd1;
    localparam logic [1:0] CMD_LOAD_GOTO = 2'd2;
    localparam logic [1:0] CMD_LOAD_PROD = 2'd3;

    // Action kinds
    localparam logic [1:0] KIND_NONE   = 2'd0;
    localparam logic [1:0] KIND_SHIFT  = 2'd1;
    localparam logic [1:0] KIND_REDUCE = 2'd2;
    localparam logic [1:0] KIND_ACCEPT = 2'd3;

    // Result events
    localparam logic [1:0] EV_SHIFT  = 2'd0;
    localparam logic [1:0] EV_REDUCE = 2'd1;
    localparam logic [1:0] EV_ACCEPT = 2'd2;
    localparam logic [1:0] EV_ERROR  = 2'd3;

    // Table load request
    typedef struct packed {
        logic       act_we;
        logic       goto_we;
        logic       prod_we;
        logic [5:0] row;
        logic [3:0] col;
        logic [1:0] kind;
        logic [5:0] val;
        logic [3:0] rlen;
        logic [3:0] lhs;
    } t_tbl_wr;

    // Table read request
    typedef struct packed {
        logic       act_re;
        logic       goto_re;
        logic       prod_re;
        logic [5:0] act_row;
        logic [3:0] act_col;
        logic [5:0] goto_row;
        logic [3:0] goto_col;
        logic [5:0] prod_sel;
    } t_tbl_rd;

    // Registered table read data
    typedef struct packed {
        logic [1:0] act_kind;
        logic [5:0] act_val;
        logic [5:0] goto_val;
        logic [3:0] prod_rlen;
        logic [3:0] prod_lhs;
    } t_tbl_rdata;

endpackage

// ===== hdl/lrp_tables.sv =====
// ACTION, GOTO and production tables with load port, read port and clear sweep.
module lrp_tables #(
    parameter int NUM_STATES      = lrp_pkg::NUM_STATES_DEF,
    parameter int NUM_SYMBOLS     = lrp_pkg::NUM_SYMBOLS_DEF,
    parameter int NUM_PRODUCTIONS = lrp_pkg::NUM_PRODUCTIONS_DEF,
    parameter int CLR_W           = 10
) (
    input  logic                i_clk,
    input  logic                i_clr,
    input  logic [CLR_W-1:0]    i_clr_idx,
    input  lrp_pkg::t_tbl_wr    i_wr,
    input  lrp_pkg::t_tbl_rd    i_rd,
    output lrp_pkg::t_tbl_rdata o_rd
);

    localparam int A_ROWS  = (NUM_STATES < lrp_pkg::ROW_SPAN) ? NUM_STATES : lrp_pkg::ROW_SPAN;
    localparam int A_COLS  = (NUM_SYMBOLS < lrp_pkg::COL_SPAN) ? NUM_SYMBOLS : lrp_pkg::COL_SPAN;
    localparam int A_DEPTH = A_ROWS * A_COLS;
    localparam int AW      = $clog2(A_DEPTH);
    localparam int P_DEPTH = (NUM_PRODUCTIONS < lrp_pkg::ROW_SPAN) ? NUM_PRODUCTIONS
                                                                    : lrp_pkg::ROW_SPAN;
    localparam int PW      = (P_DEPTH > 1) ? $clog2(P_DEPTH) : 1;

    logic [7:0] mem_act  [A_DEPTH];
    logic [5:0] mem_goto [A_DEPTH];
    logic [7:0] mem_prod [P_DEPTH];

    logic [7:0] r_act_q;
    logic [5:0] r_goto_q;
    logic [7:0] r_prod_q;

    logic [31:0]   wr_lin, act_lin, goto_lin;
    logic          wr_cell_ok, wr_prod_ok;
    logic          act_we, goto_we, prod_we;
    logic [AW-1:0] tbl_wa;
    logic [PW-1:0] prod_wa;
    logic [7:0]    act_wd, prod_wd;
    logic [5:0]    goto_wd;

    always_comb begin
        wr_lin     = 32'(i_wr.row) * A_COLS + 32'(i_wr.col);
        act_lin    = 32'(i_rd.act_row) * A_COLS + 32'(i_rd.act_col);
        goto_lin   = 32'(i_rd.goto_row) * A_COLS + 32'(i_rd.goto_col);
        wr_cell_ok = (32'(i_wr.row) < NUM_STATES) && (32'(i_wr.col) < NUM_SYMBOLS);
        wr_prod_ok = (32'(i_wr.row) < NUM_PRODUCTIONS);

        // clear sweep owns the write port after reset
        if (i_clr) begin
            act_we  = (32'(i_clr_idx) < A_DEPTH);
            goto_we = act_we;
            prod_we = (32'(i_clr_idx) < P_DEPTH);
            tbl_wa  = i_clr_idx[AW-1:0];
            prod_wa = i_clr_idx[PW-1:0];
            act_wd  = '0;
            goto_wd = '0;
            prod_wd = '0;
        end else begin
            act_we  = i_wr.act_we && wr_cell_ok;
            goto_we = i_wr.goto_we && wr_cell_ok;
            prod_we = i_wr.prod_we && wr_prod_ok;
            tbl_wa  = wr_lin[AW-1:0];
            prod_wa = i_wr.row[PW-1:0];
            act_wd  = {i_wr.kind, i_wr.val};
            goto_wd = i_wr.val;
            prod_wd = {i_wr.lhs, i_wr.rlen};
        end
    end

    always_ff @(posedge i_clk) begin
        if (act_we) begin
            mem_act[tbl_wa] <= act_wd;
        end
        if (goto_we) begin
            mem_goto[tbl_wa] <= goto_wd;
        end
        if (prod_we) begin
            mem_prod[prod_wa] <= prod_wd;
        end
        if (i_rd.act_re) begin
            r_act_q <= mem_act[act_lin[AW-1:0]];
        end
        if (i_rd.goto_re) begin
            r_goto_q <= mem_goto[goto_lin[AW-1:0]];
        end
        if (i_rd.prod_re) begin
            r_prod_q <= mem_prod[i_rd.prod_sel[PW-1:0]];
        end
    end

    assign o_rd.act_kind  = r_act_q[7:6];
    assign o_rd.act_val   = r_act_q[5:0];
    assign o_rd.goto_val  = r_goto_q;
    assign o_rd.prod_rlen = r_prod_q[3:0];
    assign o_rd.prod_lhs  = r_prod_q[7:4];

endmodule

// ===== hdl/lrp_stack.sv =====
// State stack memory; the bottom entry always reads as state 0.
module lrp_stack #(
    parameter int STACK_DEPTH = lrp_pkg::STACK_DEPTH_DEF
) (
    input  logic                           i_clk,
    input  logic                           i_we,
    input  logic [$clog2(STACK_DEPTH)-1:0] i_waddr,
    input  logic [5:0]                     i_wdata,
    input  logic                           i_re,
    input  logic [$clog2(STACK_DEPTH)-1:0] i_raddr,
    output logic [5:0]                     o_rdata
);

    localparam int SW = $clog2(STACK_DEPTH);

    logic [5:0] mem_stk [STACK_DEPTH];
    logic [5:0] r_q;
    logic       r_bottom;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            mem_stk[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_q      <= mem_stk[i_raddr];
            r_bottom <= (i_raddr == SW'(0));
        end
    end

    // entry 0 is never written: it is the home state
    assign o_rdata = r_bottom ? 6'd0 : r_q;

endmodule

// ===== hdl/lr_table_driven_parse_engine.sv =====
// Top level of the table-driven LR(1) shift-reduce parse engine.
//
//  channel  | handshake          | payload
//  ---------+--------------------+---------------------------------------------------
//  input    | i_valid / o_ready  | i_command i_token i_row i_entry_kind i_entry_value
//           |                    | i_rhs_length i_lhs_symbol
//  output   | o_valid / i_ready  | o_event_res o_production o_new_state o_depth o_last
//
// A load is written straight from the idle state. For a token the ACTION table is read, and
// each reduce then reads the production table, the stack and the GOTO table in turn, each
// through one synchronous port. After reset a clearing pass zeroes the tables over
// max(ACTION rows x columns, production rows) entries (1024 by default); o_ready stays
// low until it is done. A full output register stalls the sequencer in place; the
// finished item is held there while the next step is prepared.

module lr_table_driven_parse_engine #(
    parameter int NUM_STATES      = lrp_pkg::NUM_STATES_DEF,
    parameter int NUM_SYMBOLS     = lrp_pkg::NUM_SYMBOLS_DEF,
    parameter int NUM_PRODUCTIONS = lrp_pkg::NUM_PRODUCTIONS_DEF,
    parameter int STACK_DEPTH     = lrp_pkg::STACK_DEPTH_DEF,
    parameter int MAX_REDUCES     = lrp_pkg::MAX_REDUCES_DEF
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    // item in
    input  logic       i_valid,
    output logic       o_ready,
    input  logic [1:0] i_command,
    input  logic [3:0] i_token,
    input  logic [5:0] i_row,
    input  logic [1:0] i_entry_kind,
    input  logic [5:0] i_entry_value,
    input  logic [3:0] i_rhs_length,
    input  logic [3:0] i_lhs_symbol,
    // item out
    output logic       o_valid,
    input  logic       i_ready,
    output logic [1:0] o_event_res,
    output logic [5:0] o_production,
    output logic [5:0] o_new_state,
    output logic [6:0] o_depth,
    output logic       o_last
);

    // table geometry, as clipped by the fixed row and column field widths
    localparam int A_ROWS    = (NUM_STATES < lrp_pkg::ROW_SPAN) ? NUM_STATES
                                                                 : lrp_pkg::ROW_SPAN;
    localparam int A_COLS    = (NUM_SYMBOLS < lrp_pkg::COL_SPAN) ? NUM_SYMBOLS
                                                                  : lrp_pkg::COL_SPAN;
    localparam int P_DEPTH   = (NUM_PRODUCTIONS < lrp_pkg::ROW_SPAN) ? NUM_PRODUCTIONS
                                                                      : lrp_pkg::ROW_SPAN;
    localparam int CLR_DEPTH = (A_ROWS * A_COLS > P_DEPTH) ? A_ROWS * A_COLS : P_DEPTH;
    localparam int CW        = $clog2(CLR_DEPTH);
    localparam int SW        = $clog2(STACK_DEPTH);
    localparam int SPW       = $clog2(STACK_DEPTH + 1);
    // ALU keeps a spare top bit so a pop past the bottom shows as a borrow
    localparam int LW        = ((SPW > 4) ? SPW : 4) + 1;
    localparam int RCW       = $clog2(MAX_REDUCES + 1);

    // sequencer
    localparam logic [2:0] S_CLEAR = 3'd0;  // table clearing pass
    localparam logic [2:0] S_IDLE  = 3'd1;  // take an item
    localparam logic [2:0] S_ACT   = 3'd2;  // read ACTION[top][token]
    localparam logic [2:0] S_DEC   = 3'd3;  // decode action
    localparam logic [2:0] S_PROD  = 3'd4;  // production read back: pop
    localparam logic [2:0] S_EXP   = 3'd5;  // exposed state read back: read GOTO
    localparam logic [2:0] S_GOTO  = 3'd6;  // push GOTO target, report reduce

    logic [2:0]     r_state, n_state;
    logic [CW-1:0]  r_clr_cnt, n_clr_cnt;
    logic [3:0]     r_tok, n_tok;
    logic [5:0]     r_top, n_top;
    logic [SPW-1:0] r_sp, n_sp;
    logic [SPW-1:0] r_nsp, n_nsp;
    logic [RCW-1:0] r_red, n_red;
    logic [3:0]     r_plhs, n_plhs;
    logic [5:0]     r_prod, n_prod;
    logic           r_act_ok, n_act_ok;
    logic           r_goto_ok, n_goto_ok;

    logic       r_o_valid;
    logic [1:0] r_o_event;
    logic [5:0] r_o_prod;
    logic [5:0] r_o_state;
    logic [6:0] r_o_depth;
    logic       r_o_last;

    // result staging
    logic       emit, go_home;
    logic [1:0] em_ev;
    logic [5:0] em_prod, em_state;
    logic [6:0] em_depth;
    logic       em_last;

    logic       out_free;

    // table and stack ports
    lrp_pkg::t_tbl_wr    tbl_wr;
    lrp_pkg::t_tbl_rd    tbl_rd;
    lrp_pkg::t_tbl_rdata tbl_q;
    logic                stk_we, stk_re;
    logic [SW-1:0]       stk_waddr;
    logic [5:0]          stk_wdata, stk_q;

    // shared stack-pointer ALU: push increment and reduce pop
    logic          alu_sub;
    logic [LW-1:0] alu_a, alu_b, alu_y, alu_ym1;
    logic          pop_under, pop_over;
    logic [5:0]    goto_tgt;

    always_comb begin
        alu_sub   = (r_state == S_PROD);
        alu_a     = (r_state == S_GOTO) ? LW'(r_nsp) : LW'(r_sp);
        alu_b     = alu_sub ? LW'(tbl_q.prod_rlen) : LW'(1);
        alu_y     = alu_sub ? (alu_a - alu_b) : (alu_a + alu_b);
        alu_ym1   = alu_y - LW'(1);
        // a length not below the depth leaves nothing: borrow or zero
        pop_under = alu_y[LW-1] || (alu_y == '0);
        pop_over  = (32'(alu_y) >= STACK_DEPTH);
    end

    assign out_free = !r_o_valid || i_ready;
    assign o_ready  = (r_state == S_IDLE);
    assign goto_tgt = r_goto_ok ? tbl_q.goto_val : 6'd0;

    always_comb begin
        n_state   = r_state;
        n_clr_cnt = r_clr_cnt;
        n_tok     = r_tok;
        n_top     = r_top;
        n_sp      = r_sp;
        n_nsp     = r_nsp;
        n_red     = r_red;
        n_plhs    = r_plhs;
        n_prod    = r_prod;
        n_act_ok  = r_act_ok;
        n_goto_ok = r_goto_ok;

        // error and accept both carry state 0, depth 1
        emit     = 1'b0;
        go_home  = 1'b0;
        em_ev    = lrp_pkg::EV_ERROR;
        em_prod  = 6'd0;
        em_state = 6'd0;
        em_depth = 7'd1;
        em_last  = 1'b1;

        tbl_wr.act_we  = 1'b0;
        tbl_wr.goto_we = 1'b0;
        tbl_wr.prod_we = 1'b0;
        tbl_wr.row     = i_row;
        tbl_wr.col     = i_token;
        tbl_wr.kind    = i_entry_kind;
        tbl_wr.val     = i_entry_value;
        tbl_wr.rlen    = i_rhs_length;
        tbl_wr.lhs     = i_lhs_symbol;

        tbl_rd.act_re   = 1'b0;
        tbl_rd.goto_re  = 1'b0;
        tbl_rd.prod_re  = 1'b0;
        tbl_rd.act_row  = r_top;
        tbl_rd.act_col  = r_tok;
        tbl_rd.goto_row = stk_q;
        tbl_rd.goto_col = r_plhs;
        tbl_rd.prod_sel = tbl_q.act_val;

        stk_we    = 1'b0;
        stk_waddr = r_sp[SW-1:0];
        stk_wdata = tbl_q.act_val;
        stk_re    = 1'b0;

        unique case (r_state)
            S_CLEAR: begin
                if (r_clr_cnt == CW'(CLR_DEPTH - 1)) begin
                    n_state = S_IDLE;
                end else begin
                    n_clr_cnt = r_clr_cnt + CW'(1);
                end
            end
            S_IDLE: begin
                if (i_valid) begin
                    unique case (i_command)
                        lrp_pkg::CMD_TOKEN: begin
                            n_tok   = i_token;
                            n_red   = '0;
                            n_state = S_ACT;
                        end
                        lrp_pkg::CMD_LOAD_ACT:  tbl_wr.act_we  = 1'b1;
                        lrp_pkg::CMD_LOAD_GOTO: tbl_wr.goto_we = 1'b1;
                        lrp_pkg::CMD_LOAD_PROD: tbl_wr.prod_we = 1'b1;
                        default: ;
                    endcase
                end
            end
            S_ACT: begin
                tbl_rd.act_re = 1'b1;
                n_act_ok = (32'(r_top) < NUM_STATES) && (32'(r_tok) < NUM_SYMBOLS);
                n_state  = S_DEC;
            end
            S_DEC: begin
                if (!r_act_ok || tbl_q.act_kind == lrp_pkg::KIND_NONE) begin
                    if (out_free) begin
                        emit    = 1'b1;
                        go_home = 1'b1;
                        n_state = S_IDLE;
                    end
                end else if (tbl_q.act_kind == lrp_pkg::KIND_ACCEPT) begin
                    if (out_free) begin
                        emit    = 1'b1;
                        go_home = 1'b1;
                        em_ev   = lrp_pkg::EV_ACCEPT;
                        n_state = S_IDLE;
                    end
                end else if (tbl_q.act_kind == lrp_pkg::KIND_SHIFT) begin
                    if (out_free) begin
                        emit    = 1'b1;
                        n_state = S_IDLE;
                        if (32'(r_sp) >= STACK_DEPTH) begin
                            go_home = 1'b1;
                        end else begin
                            stk_we   = 1'b1;
                            n_sp     = SPW'(alu_y);
                            n_top    = tbl_q.act_val;
                            em_ev    = lrp_pkg::EV_SHIFT;
                            em_state = tbl_q.act_val;
                            em_depth = 7'(alu_y);
                        end
                    end
                end else begin
                    // reduce: bounded chain, production must exist
                    if ((32'(r_red) >= MAX_REDUCES) ||
                        (32'(tbl_q.act_val) >= NUM_PRODUCTIONS)) begin
                        if (out_free) begin
                            emit    = 1'b1;
                            go_home = 1'b1;
                            n_state = S_IDLE;
                        end
                    end else begin
                        tbl_rd.prod_re = 1'b1;
                        n_prod  = tbl_q.act_val;
                        n_state = S_PROD;
                    end
                end
            end
            S_PROD: begin
                if (pop_under || pop_over) begin
                    if (out_free) begin
                        emit    = 1'b1;
                        go_home = 1'b1;
                        n_state = S_IDLE;
                    end
                end else begin
                    stk_re  = 1'b1;
                    n_nsp   = SPW'(alu_y);
                    n_plhs  = tbl_q.prod_lhs;
                    n_state = S_EXP;
                end
            end
            S_EXP: begin
                tbl_rd.goto_re = 1'b1;
                n_goto_ok = (32'(stk_q) < NUM_STATES) && (32'(r_plhs) < NUM_SYMBOLS);
                n_state   = S_GOTO;
            end
            S_GOTO: begin
                if (out_free) begin
                    emit      = 1'b1;
                    stk_we    = 1'b1;
                    stk_waddr = r_nsp[SW-1:0];
                    stk_wdata = goto_tgt;
                    n_sp      = SPW'(alu_y);
                    n_top     = goto_tgt;
                    n_red     = r_red + RCW'(1);
                    em_ev     = lrp_pkg::EV_REDUCE;
                    em_prod   = r_prod;
                    em_state  = goto_tgt;
                    em_depth  = 7'(alu_y);
                    em_last   = 1'b0;
                    n_state   = S_ACT;
                end
            end
            default: n_state = S_IDLE;
        endcase

        if (go_home) begin
            n_sp  = SPW'(1);
            n_top = 6'd0;
        end
    end

    // control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_CLEAR;
            r_clr_cnt <= '0;
            r_sp      <= SPW'(1);
            r_top     <= 6'd0;
            r_o_valid <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_clr_cnt <= n_clr_cnt;
            r_sp      <= n_sp;
            r_top     <= n_top;
            if (emit) begin
                r_o_valid <= 1'b1;
            end else if (i_ready) begin
                r_o_valid <= 1'b0;
            end
        end
    end

    // working payload
    always_ff @(posedge i_clk) begin
        r_tok     <= n_tok;
        r_nsp     <= n_nsp;
        r_red     <= n_red;
        r_plhs    <= n_plhs;
        r_prod    <= n_prod;
        r_act_ok  <= n_act_ok;
        r_goto_ok <= n_goto_ok;
        if (emit) begin
            r_o_event <= em_ev;
            r_o_prod  <= em_prod;
            r_o_state <= em_state;
            r_o_depth <= em_depth;
            r_o_last  <= em_last;
        end
    end

    lrp_tables #(
        .NUM_STATES     (NUM_STATES),
        .NUM_SYMBOLS    (NUM_SYMBOLS),
        .NUM_PRODUCTIONS(NUM_PRODUCTIONS),
        .CLR_W          (CW)
    ) u_tables (
        .i_clk    (i_clk),
        .i_clr    (r_state == S_CLEAR),
        .i_clr_idx(r_clr_cnt),
        .i_wr     (tbl_wr),
        .i_rd     (tbl_rd),
        .o_rd     (tbl_q)
    );

    lrp_stack #(
        .STACK_DEPTH(STACK_DEPTH)
    ) u_stack (
        .i_clk  (i_clk),
        .i_we   (stk_we),
        .i_waddr(stk_waddr),
        .i_wdata(stk_wdata),
        .i_re   (stk_re),
        .i_raddr(alu_ym1[SW-1:0]),
        .o_rdata(stk_q)
    );

    assign o_valid      = r_o_valid;
    assign o_event_res  = r_o_event;
    assign o_production = r_o_prod;
    assign o_new_state  = r_o_state;
    assign o_depth      = r_o_depth;
    assign o_last       = r_o_last;

endmodule
